// ===== hdl/dual_slot_record_selector_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual slot record selector
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_SLOT_RECORD_SELECTOR_MACROS_SVH
`define DUAL_SLOT_RECORD_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: ante |-> cons
`define DSRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication: ante |=> cons
`define DSRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSRS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define DSRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/dsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrs_pkg
// Types, constants and the CRC byte update shared by the record selector.
// ----------------------------------------------------------------------------
package dsrs_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int POS_W        = $clog2(RECORD_BYTES);
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [15:0] MAGIC_RESET   = 16'h2004;
  localparam logic [15:0] VERSION_RESET = 16'h0100;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_VERSION = 1'b1;

  // byte offsets inside a record
  localparam logic [POS_W-1:0] POS_MAGIC_LO   = 4'd0;
  localparam logic [POS_W-1:0] POS_MAGIC_HI   = 4'd1;
  localparam logic [POS_W-1:0] POS_VERSION_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_VERSION_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_SEQ_LO     = 4'd4;
  localparam logic [POS_W-1:0] POS_SEQ_HI     = 4'd5;
  localparam logic [POS_W-1:0] POS_TEMP_LO    = 4'd6;
  localparam logic [POS_W-1:0] POS_TEMP_HI    = 4'd7;
  localparam logic [POS_W-1:0] POS_SPEED_LO   = 4'd8;
  localparam logic [POS_W-1:0] POS_SPEED_HI   = 4'd9;
  localparam logic [POS_W-1:0] POS_TIME_0     = 4'd10;
  localparam logic [POS_W-1:0] POS_TIME_1     = 4'd11;
  localparam logic [POS_W-1:0] POS_TIME_2     = 4'd12;
  localparam logic [POS_W-1:0] POS_TIME_3     = 4'd13;
  localparam logic [POS_W-1:0] POS_CRC_LO     = 4'd14;
  localparam logic [POS_W-1:0] POS_CRC_HI     = 4'd15;

  localparam logic SLOT_A = 1'b0;
  localparam logic SLOT_B = 1'b1;

  typedef struct packed {
    logic       slot;
    logic [7:0] data_byte;
    logic       read_ok;
    logic       last_of_record;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        chosen_slot;
    logic [15:0] temperature;
    logic [15:0] speed;
    logic [31:0] run_time;
    logic [15:0] sequence_res;
  } result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/dsrs_in_reg.sv =====
// ----------------------------------------------------------------------------
// dsrs_in_reg
// Input register: holds one accepted byte until the record stage takes it.
// ----------------------------------------------------------------------------
module dsrs_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsrs_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               held,
  output dsrs_pkg::in_item_t item
);

  logic held_next;

  // free slot, or the held byte leaves this cycle
  assign in_ready = !held || advance;

  always_comb begin
    held_next = held;
    if (in_valid && in_ready) begin
      held_next = 1'b1;
    end else if (advance) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/dsrs_record.sv =====
// ----------------------------------------------------------------------------
// dsrs_record
// Per-byte record check (header, CRC, read status), field capture, slot A
// hold and the A/B choice.
// ----------------------------------------------------------------------------
module dsrs_record (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dsrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             step,
  input  dsrs_pkg::in_item_t               item,
  output dsrs_pkg::result_t                result
);

  logic [15:0] record_magic;
  logic [15:0] record_version;

  logic [dsrs_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  header_byte, header_byte_next;
  logic        header_match, header_match_next;
  logic        read_good, read_good_next;
  logic [15:0] cur_seq, cur_seq_next;
  logic [15:0] cur_temp, cur_temp_next;
  logic [15:0] cur_speed, cur_speed_next;
  logic [31:0] cur_time, cur_time_next;
  logic        held_valid, held_valid_next;
  logic [15:0] held_seq, held_temp, held_speed;
  logic [31:0] held_time;

  logic [15:0] word;
  logic        crc_match;
  logic        valid;
  logic [15:0] seq_diff;
  logic        pick_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_magic   <= dsrs_pkg::MAGIC_RESET;
      record_version <= dsrs_pkg::VERSION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsrs_pkg::REG_MAGIC:   record_magic   <= cfg_data;
        dsrs_pkg::REG_VERSION: record_version <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    word               = {item.data_byte, header_byte};
    running_crc_next   = running_crc;
    header_byte_next   = header_byte;
    header_match_next  = header_match;
    read_good_next     = read_good && item.read_ok;
    cur_seq_next       = cur_seq;
    cur_temp_next      = cur_temp;
    cur_speed_next     = cur_speed;
    cur_time_next      = cur_time;
    crc_match          = 1'b0;

    if (byte_position < dsrs_pkg::POS_CRC_LO) begin
      running_crc_next = dsrs_pkg::crc_byte(running_crc, item.data_byte);
    end

    unique case (byte_position)
      dsrs_pkg::POS_MAGIC_LO, dsrs_pkg::POS_VERSION_LO, dsrs_pkg::POS_CRC_LO: begin
        header_byte_next = item.data_byte;
      end
      dsrs_pkg::POS_MAGIC_HI: begin
        if (word != record_magic) header_match_next = 1'b0;
      end
      dsrs_pkg::POS_VERSION_HI: begin
        if (word != record_version) header_match_next = 1'b0;
      end
      dsrs_pkg::POS_SEQ_LO:   cur_seq_next[7:0]    = item.data_byte;
      dsrs_pkg::POS_SEQ_HI:   cur_seq_next[15:8]   = item.data_byte;
      dsrs_pkg::POS_TEMP_LO:  cur_temp_next[7:0]   = item.data_byte;
      dsrs_pkg::POS_TEMP_HI:  cur_temp_next[15:8]  = item.data_byte;
      dsrs_pkg::POS_SPEED_LO: cur_speed_next[7:0]  = item.data_byte;
      dsrs_pkg::POS_SPEED_HI: cur_speed_next[15:8] = item.data_byte;
      dsrs_pkg::POS_TIME_0:   cur_time_next[7:0]   = item.data_byte;
      dsrs_pkg::POS_TIME_1:   cur_time_next[15:8]  = item.data_byte;
      dsrs_pkg::POS_TIME_2:   cur_time_next[23:16] = item.data_byte;
      dsrs_pkg::POS_TIME_3:   cur_time_next[31:24] = item.data_byte;
      default: begin
        // stored checksum high byte; an unmarked sixteenth byte spoils the record
        crc_match = (word == running_crc);
        if (!item.last_of_record) read_good_next = 1'b0;
      end
    endcase

    valid = read_good_next && header_match_next && crc_match &&
            (byte_position == dsrs_pkg::POS_CRC_HI);

    byte_position_next = byte_position + 4'd1;
    held_valid_next    = held_valid;
    if (item.last_of_record) begin
      byte_position_next = '0;
      running_crc_next   = dsrs_pkg::CRC_INIT;
      header_match_next  = 1'b1;
      read_good_next     = 1'b1;
      held_valid_next    = (item.slot == dsrs_pkg::SLOT_A) ? valid : 1'b0;
    end

    // A wins when B is bad or A is strictly newer under wraparound
    seq_diff = held_seq - cur_seq_next;
    pick_a   = held_valid && (!valid || (!seq_diff[15] && (seq_diff != 16'd0)));

    result = '0;
    if (held_valid || valid) begin
      result.found = 1'b1;
      if (pick_a) begin
        result.chosen_slot  = dsrs_pkg::SLOT_A;
        result.temperature  = held_temp;
        result.speed        = held_speed;
        result.run_time     = held_time;
        result.sequence_res = held_seq;
      end else begin
        result.chosen_slot  = dsrs_pkg::SLOT_B;
        result.temperature  = cur_temp_next;
        result.speed        = cur_speed_next;
        result.run_time     = cur_time_next;
        result.sequence_res = cur_seq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= dsrs_pkg::CRC_INIT;
      header_match  <= 1'b1;
      read_good     <= 1'b1;
      held_valid    <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      header_match  <= header_match_next;
      read_good     <= read_good_next;
      held_valid    <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      header_byte <= header_byte_next;
      cur_seq     <= cur_seq_next;
      cur_temp    <= cur_temp_next;
      cur_speed   <= cur_speed_next;
      cur_time    <= cur_time_next;
      if (item.last_of_record && (item.slot == dsrs_pkg::SLOT_A)) begin
        held_seq   <= cur_seq_next;
        held_temp  <= cur_temp_next;
        held_speed <= cur_speed_next;
        held_time  <= cur_time_next;
      end
    end
  end

endmodule

// ===== hdl/dsrs_out_reg.sv =====
// ----------------------------------------------------------------------------
// dsrs_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module dsrs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dsrs_pkg::result_t result_in,
  output logic              out_valid,
  input  logic              out_ready,
  output dsrs_pkg::result_t result
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

// ===== hdl/dual_slot_record_selector.sv =====
// ----------------------------------------------------------------------------
// dual_slot_record_selector
// Checks two 16-byte records (slot A, then slot B) and reports the newer
// valid one after the last byte of slot B.
//
//   channel   direction  tdata                     tuser / tlast
//   s_axis    in         data_byte                 slot, read_ok / last_of_record
//   m_axis    out        temp, speed, time, seq    found, chosen_slot
//   cfg       in         record_magic, record_version by cfg_index
//
// One byte per cycle while no result stalls. A byte is held in the input register
// and is folded into the record state as it leaves; the result of the final slot B
// byte is loaded into the output register as that byte leaves the input register.
// Synchronous reset clears all control state and loads the register defaults.
// A full, stalled output register holds a slot B final byte in the input
// register, which stalls the input; all other bytes keep flowing.
// ----------------------------------------------------------------------------
`include "dual_slot_record_selector_macros.svh"

module dual_slot_record_selector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // data_byte
  input  logic [1:0]                       s_axis_tuser,  // slot, read_ok
  input  logic                             s_axis_tlast,  // last_of_record
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // temperature, speed, run_time, sequence_res
  output logic [79:0]                      m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,  // found, chosen_slot
  input  logic                             cfg_we,
  input  logic [dsrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dsrs_pkg::in_item_t s_item;
  dsrs_pkg::in_item_t item;
  dsrs_pkg::result_t  result_d;
  dsrs_pkg::result_t  result_q;
  logic               held;
  logic               emit;
  logic               advance;

  assign s_item.slot           = s_axis_tuser[0];
  assign s_item.data_byte      = s_axis_tdata;
  assign s_item.read_ok        = s_axis_tuser[1];
  assign s_item.last_of_record = s_axis_tlast;

  // a slot B final byte needs room in the output register
  assign emit    = held && item.last_of_record && (item.slot == dsrs_pkg::SLOT_B);
  assign advance = held && (!emit || !m_axis_tvalid || m_axis_tready);

  dsrs_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (s_item),
    .advance  (advance),
    .held     (held),
    .item     (item)
  );

  dsrs_record u_record (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (item),
    .result    (result_d)
  );

  dsrs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .result_in (result_d),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result_q)
  );

  assign m_axis_tdata = {result_q.sequence_res, result_q.run_time,
                         result_q.speed, result_q.temperature};
  assign m_axis_tuser = {result_q.chosen_slot, result_q.found};

  `DSRS_ASSERT_NEXT(a_emit_fills_out, clk, rst, advance && emit, m_axis_tvalid, "result not loaded")
  `DSRS_ASSERT_NOW(a_no_overwrite, clk, rst, m_axis_tvalid && !m_axis_tready && emit, !advance, "pending result overwritten")
  `DSRS_ASSERT_NOW(a_in_hold, clk, rst, held && !advance, !s_axis_tready, "held byte overwritten")
  `DSRS_ASSERT_NOW(a_empty_result, clk, rst, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata == 80'd0) && !m_axis_tuser[1], "empty result not zero")

endmodule
